### rtl/accel_tilt_direction_classifier_defines.svh
// ----------------------------------------------------------------------------
// Tilt classifier assertion macros
// Shared property forms for the tilt classifier checks.
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_DIRECTION_CLASSIFIER_DEFINES_SVH
`define ACCEL_TILT_DIRECTION_CLASSIFIER_DEFINES_SVH

// same-cycle implication
`define TDC_ASSERT_HOLDS(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tdc check failed");

// next-cycle implication
`define TDC_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tdc check failed");

`endif

### rtl/tdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt classifier package
// Widths, codes, shared types and the color level table.
// ----------------------------------------------------------------------------
package tdc_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int WINDOW_LOG2_DEF = 4;
  localparam int THR_W           = 15;
  localparam int CFG_IDX_W       = 1;
  localparam int DIR_W           = 3;
  localparam int PIX_W           = 3;
  localparam int LEVEL_W         = 8;

  localparam logic [THR_W-1:0] TILT_RESET = 15'd768;
  localparam logic [THR_W-1:0] LEAN_RESET = 15'd205;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILT = 1'b0,
    CFG_LEAN = 1'b1
  } cfg_reg_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_FLAT    = 3'd0,
    DIR_FLIPPED = 3'd1,
    DIR_TILTED  = 3'd2,
    DIR_DOWN    = 3'd3,
    DIR_RIGHT   = 3'd4,
    DIR_UP      = 3'd5,
    DIR_LEFT    = 3'd6
  } dir_t;

  localparam logic [PIX_W-1:0] PIX_NONE  = 3'd0;
  localparam logic [PIX_W-1:0] PIX_DOWN  = 3'd0;
  localparam logic [PIX_W-1:0] PIX_RIGHT = 3'd2;
  localparam logic [PIX_W-1:0] PIX_UP    = 3'd4;
  localparam logic [PIX_W-1:0] PIX_LEFT  = 3'd7;

  typedef struct packed {
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] y;
    logic [SAMPLE_W-1:0] z;
  } axes_t;

  typedef struct packed {
    logic [THR_W-1:0] tilt;
    logic [THR_W-1:0] lean;
  } thresh_t;

  typedef struct packed {
    axes_t              avg;
    dir_t               direction;
    logic               pixel_on;
    logic [PIX_W-1:0]   pixel_number;
    logic               lean_right;
    logic               lean_left;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } result_t;

  // whole part of a Q8.8 mean scaled by 255/10, saturated
  function automatic logic [LEVEL_W-1:0] colour_level(input logic [SAMPLE_W-1:0] avg);
    logic [7:0]         whole;
    logic [LEVEL_W-1:0] lvl;
    whole = avg[SAMPLE_W-1:8];
    if (avg[SAMPLE_W-1]) begin
      lvl = 8'd0;
    end else begin
      case (whole)
        8'd0:    lvl = 8'd0;
        8'd1:    lvl = 8'd25;
        8'd2:    lvl = 8'd51;
        8'd3:    lvl = 8'd76;
        8'd4:    lvl = 8'd102;
        8'd5:    lvl = 8'd127;
        8'd6:    lvl = 8'd153;
        8'd7:    lvl = 8'd178;
        8'd8:    lvl = 8'd204;
        8'd9:    lvl = 8'd229;
        default: lvl = 8'd255;
      endcase
    end
    return lvl;
  endfunction

endpackage

### rtl/tdc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt classifier window cell
// Holds one three-axis sample and passes it on to the next cell on shift.
// ----------------------------------------------------------------------------
module tdc_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  tdc_pkg::axes_t d,
  output tdc_pkg::axes_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

### rtl/tdc_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt classifier moving window
// Chain of sample cells with running sums; presents the windowed means.
// ----------------------------------------------------------------------------
module tdc_window #(
  parameter int WINDOW_LOG2 = tdc_pkg::WINDOW_LOG2_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  tdc_pkg::axes_t sample,
  output tdc_pkg::axes_t avg
);

  localparam int WINDOW_LEN = 1 << WINDOW_LOG2;
  localparam int SW         = tdc_pkg::SAMPLE_W;
  localparam int SUM_W      = SW + WINDOW_LOG2;

  tdc_pkg::axes_t tap [WINDOW_LEN+1];
  tdc_pkg::axes_t oldest;

  logic [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic [SUM_W-1:0] sum_x_next, sum_y_next, sum_z_next;

  assign tap[0] = sample;

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    tdc_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (load),
      .d     (tap[i]),
      .q     (tap[i+1])
    );
  end

  assign oldest = tap[WINDOW_LEN];

  // add the new sample, drop the one leaving the window
  always_comb begin
    sum_x_next = sum_x + {{WINDOW_LOG2{sample.x[SW-1]}}, sample.x}
                       - {{WINDOW_LOG2{oldest.x[SW-1]}}, oldest.x};
    sum_y_next = sum_y + {{WINDOW_LOG2{sample.y[SW-1]}}, sample.y}
                       - {{WINDOW_LOG2{oldest.y[SW-1]}}, oldest.y};
    sum_z_next = sum_z + {{WINDOW_LOG2{sample.z[SW-1]}}, sample.z}
                       - {{WINDOW_LOG2{oldest.z[SW-1]}}, oldest.z};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x <= '0;
      sum_y <= '0;
      sum_z <= '0;
    end else if (load) begin
      sum_x <= sum_x_next;
      sum_y <= sum_y_next;
      sum_z <= sum_z_next;
    end
  end

  assign avg.x = sum_x[SUM_W-1:WINDOW_LOG2];
  assign avg.y = sum_y[SUM_W-1:WINDOW_LOG2];
  assign avg.z = sum_z[SUM_W-1:WINDOW_LOG2];

endmodule

### rtl/tdc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt classifier decision stage
// Direction, held pixel, lean flags and colour levels into the output register.
// ----------------------------------------------------------------------------
module tdc_classify (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tdc_pkg::axes_t    avg,
  input  tdc_pkg::thresh_t  thr,
  output tdc_pkg::result_t  res
);

  localparam int SW = tdc_pkg::SAMPLE_W;

  tdc_pkg::result_t res_next;

  logic [SW:0]   mag_x, mag_y, tilt_e;
  logic [SW+1:0] y_e, lean_e, lean_neg;
  logic          x_neg, x_pos, y_neg, y_pos, z_pos;
  logic          tilted, is_down, is_right, is_up, is_left, updown;

  always_comb begin
    x_neg = avg.x[SW-1];
    y_neg = avg.y[SW-1];
    x_pos = !avg.x[SW-1] && (avg.x != '0);
    y_pos = !avg.y[SW-1] && (avg.y != '0);
    z_pos = !avg.z[SW-1] && (avg.z != '0);

    mag_x  = x_neg ? ((SW+1)'(0) - {1'b1, avg.x}) : {1'b0, avg.x};
    mag_y  = y_neg ? ((SW+1)'(0) - {1'b1, avg.y}) : {1'b0, avg.y};
    tilt_e = (SW+1)'(thr.tilt);

    y_e      = {{2{avg.y[SW-1]}}, avg.y};
    lean_e   = (SW+2)'(thr.lean);
    lean_neg = (SW+2)'(0) - lean_e;

    tilted   = (mag_x > tilt_e) || (mag_y > tilt_e);
    is_down  = x_neg && (mag_y < tilt_e);
    is_right = y_neg && (mag_x < tilt_e);
    is_up    = x_pos && (mag_y < tilt_e);
    is_left  = y_pos && (mag_x < tilt_e);
    updown   = is_down || is_up;

    res_next              = res;
    res_next.avg          = avg;
    res_next.lean_right   = 1'b0;
    res_next.lean_left    = 1'b0;
    res_next.red          = tdc_pkg::colour_level(avg.x);
    res_next.green        = tdc_pkg::colour_level(avg.y);
    res_next.blue         = tdc_pkg::colour_level(avg.z);

    if (tilted) begin
      res_next.direction = tdc_pkg::DIR_TILTED;
      // earlier tests take precedence
      if (is_left) begin
        res_next.direction    = tdc_pkg::DIR_LEFT;
        res_next.pixel_on     = 1'b1;
        res_next.pixel_number = tdc_pkg::PIX_LEFT;
      end else if (is_up) begin
        res_next.direction    = tdc_pkg::DIR_UP;
        res_next.pixel_on     = 1'b1;
        res_next.pixel_number = tdc_pkg::PIX_UP;
      end else if (is_right) begin
        res_next.direction    = tdc_pkg::DIR_RIGHT;
        res_next.pixel_on     = 1'b1;
        res_next.pixel_number = tdc_pkg::PIX_RIGHT;
      end else if (is_down) begin
        res_next.direction    = tdc_pkg::DIR_DOWN;
        res_next.pixel_on     = 1'b1;
        res_next.pixel_number = tdc_pkg::PIX_DOWN;
      end
      if (updown) begin
        res_next.lean_right = $signed(y_e) < $signed(lean_neg);
        res_next.lean_left  = $signed(y_e) > $signed(lean_e);
      end
    end else if (z_pos) begin
      res_next.direction    = tdc_pkg::DIR_FLAT;
      res_next.pixel_on     = 1'b0;
      res_next.pixel_number = tdc_pkg::PIX_NONE;
    end else begin
      res_next.direction = tdc_pkg::DIR_FLIPPED;
    end
  end

  // pixel fields double as the held pixel state
  always_ff @(posedge clk) begin
    if (rst) begin
      res.pixel_on     <= 1'b0;
      res.pixel_number <= tdc_pkg::PIX_NONE;
    end else if (load) begin
      res <= res_next;
    end
  end

endmodule

### rtl/accel_tilt_direction_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accelerometer tilt direction classifier
// Windowed mean of three-axis Q8.8 samples, tilt direction and held LED pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one accel_x/y/z sample triple per
//   transaction; output channel (out_valid/out_ready) returns one result per
//   sample, in order: the three means, direction, held pixel, lean flags and
//   color levels.
//   The window sums register a sample, then the decision stage its result.
//   Throughput: one transaction per cycle while out_ready is high, set by the
//   running-sum update in the window and the single decision stage.
//   The window is a row of WINDOW_LEN sample cells that shift once per
//   accepted sample; the last cell supplies the sample leaving the sum.
//   A full output register holds its result while out_ready is low; one more
//   sample is taken into the window stage, then in_ready drops.
//   Reset clears the window cells, the running sums, the held pixel and both
//   valid flags, and loads the default thresholds. The user writes thresholds
//   via cfg_write/cfg_index/cfg_data only while the block is idle, unenforced.
// ----------------------------------------------------------------------------
module accel_tilt_direction_classifier #(
  parameter int WINDOW_LOG2 = tdc_pkg::WINDOW_LOG2_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [tdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tdc_pkg::THR_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tdc_pkg::SAMPLE_W-1:0] accel_x,
  input  logic signed [tdc_pkg::SAMPLE_W-1:0] accel_y,
  input  logic signed [tdc_pkg::SAMPLE_W-1:0] accel_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tdc_pkg::SAMPLE_W-1:0] avg_x,
  output logic signed [tdc_pkg::SAMPLE_W-1:0] avg_y,
  output logic signed [tdc_pkg::SAMPLE_W-1:0] avg_z,
  output logic [tdc_pkg::DIR_W-1:0]           direction,
  output logic                                pixel_on,
  output logic [tdc_pkg::PIX_W-1:0]           pixel_number,
  output logic                                lean_right,
  output logic                                lean_left,
  output logic [tdc_pkg::LEVEL_W-1:0]         red_level,
  output logic [tdc_pkg::LEVEL_W-1:0]         green_level,
  output logic [tdc_pkg::LEVEL_W-1:0]         blue_level
);

  tdc_pkg::thresh_t thr;
  tdc_pkg::axes_t   sample;
  tdc_pkg::axes_t   avg;
  tdc_pkg::result_t res;

  logic win_valid;
  logic advance;
  logic take_in;
  logic load_out;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !win_valid || advance;
  assign take_in  = in_valid && in_ready;
  assign load_out = win_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.tilt <= tdc_pkg::TILT_RESET;
      thr.lean <= tdc_pkg::LEAN_RESET;
    end else if (cfg_write) begin
      case (tdc_pkg::cfg_reg_t'(cfg_index))
        tdc_pkg::CFG_TILT: thr.tilt <= cfg_data;
        tdc_pkg::CFG_LEAN: thr.lean <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take_in) begin
        win_valid <= 1'b1;
      end else if (load_out) begin
        win_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sample.x = accel_x;
  assign sample.y = accel_y;
  assign sample.z = accel_z;

  tdc_window #(
    .WINDOW_LOG2 (WINDOW_LOG2)
  ) u_window (
    .clk    (clk),
    .rst    (rst),
    .load   (take_in),
    .sample (sample),
    .avg    (avg)
  );

  tdc_classify u_classify (
    .clk  (clk),
    .rst  (rst),
    .load (load_out),
    .avg  (avg),
    .thr  (thr),
    .res  (res)
  );

  assign avg_x        = res.avg.x;
  assign avg_y        = res.avg.y;
  assign avg_z        = res.avg.z;
  assign direction    = res.direction;
  assign pixel_on     = res.pixel_on;
  assign pixel_number = res.pixel_number;
  assign lean_right   = res.lean_right;
  assign lean_left    = res.lean_left;
  assign red_level    = res.red;
  assign green_level  = res.green;
  assign blue_level   = res.blue;

endmodule

### rtl/tdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt classifier port checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "accel_tilt_direction_classifier_defines.svh"

module tdc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tdc_pkg::DIR_W-1:0]   direction,
  input logic                        pixel_on,
  input logic [tdc_pkg::PIX_W-1:0]   pixel_number,
  input logic                        lean_right,
  input logic                        lean_left
);

  logic dir_flat;
  logic dir_left;
  logic dir_updown;
  logic lean_any;
  logic pix_none;
  logic pix_left;

  assign dir_flat   = (direction == tdc_pkg::DIR_FLAT);
  assign dir_left   = (direction == tdc_pkg::DIR_LEFT);
  assign dir_updown = (direction == tdc_pkg::DIR_DOWN) || (direction == tdc_pkg::DIR_UP);
  assign lean_any   = lean_right || lean_left;
  assign pix_none   = (pixel_number == tdc_pkg::PIX_NONE);
  assign pix_left   = (pixel_number == tdc_pkg::PIX_LEFT);

  `TDC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(direction))

  `TDC_ASSERT_HOLDS(a_pix_off_zero, clk, rst, out_valid && !pixel_on, pix_none)

  `TDC_ASSERT_HOLDS(a_flat_clears, clk, rst, out_valid && dir_flat, !pixel_on)

  `TDC_ASSERT_HOLDS(a_lean_updown, clk, rst, out_valid && lean_any, dir_updown)

  `TDC_ASSERT_HOLDS(a_left_pixel, clk, rst, out_valid && dir_left, pixel_on && pix_left)

endmodule

bind accel_tilt_direction_classifier tdc_checker u_tdc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .direction    (direction),
  .pixel_on     (pixel_on),
  .pixel_number (pixel_number),
  .lean_right   (lean_right),
  .lean_left    (lean_left)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt classifier testbench
// Sends accelerometer sample triples under random idling, long output stalls
// and swept thresholds. Each accepted sample runs through a local model of the
// moving-average window, the tilt classifier and the held pixel. Every result
// transaction is compared field by field, in order, with that model's output.
// ----------------------------------------------------------------------------
module tb_top;
  import tdc_pkg::*;

  localparam int WIN_LEN = 1 << WINDOW_LOG2_DEF;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean_x;
    logic signed [SAMPLE_W-1:0] mean_y;
    logic signed [SAMPLE_W-1:0] mean_z;
    dir_t                       direction;
    logic                       pixel_on;
    logic [PIX_W-1:0]           pixel_number;
    logic                       lean_right;
    logic                       lean_left;
    logic [LEVEL_W-1:0]         red;
    logic [LEVEL_W-1:0]         green;
    logic [LEVEL_W-1:0]         blue;
  } reading_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  cfg_reg_t                   cfg_index = CFG_TILT;
  logic [THR_W-1:0]           cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] accel_x = '0;
  logic signed [SAMPLE_W-1:0] accel_y = '0;
  logic signed [SAMPLE_W-1:0] accel_z = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] avg_x;
  logic signed [SAMPLE_W-1:0] avg_y;
  logic signed [SAMPLE_W-1:0] avg_z;
  logic [DIR_W-1:0]           direction;
  logic                       pixel_on;
  logic [PIX_W-1:0]           pixel_number;
  logic                       lean_right;
  logic                       lean_left;
  logic [LEVEL_W-1:0]         red_level;
  logic [LEVEL_W-1:0]         green_level;
  logic [LEVEL_W-1:0]         blue_level;

  // model state
  logic signed [SAMPLE_W-1:0] sample_window [3][WIN_LEN] = '{default: '0};
  logic signed [SAMPLE_W+3:0] axis_sum [3] = '{default: '0};
  int                         slot_ptr = 0;
  logic                       held_lit = 1'b0;
  logic [PIX_W-1:0]           held_pix = PIX_NONE;
  logic [THR_W-1:0]           tilt_thr = TILT_RESET;
  logic [THR_W-1:0]           lean_thr = LEAN_RESET;

  reading_t expected_readings [$];
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_cycles = 0;
  int       samples_sent = 0;
  int       readings_checked = 0;
  int       error_count = 0;
  int       dir_seen [7] = '{default: 0};

  accel_tilt_direction_classifier dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .avg_x        (avg_x),
    .avg_y        (avg_y),
    .avg_z        (avg_z),
    .direction    (direction),
    .pixel_on     (pixel_on),
    .pixel_number (pixel_number),
    .lean_right   (lean_right),
    .lean_left    (lean_left),
    .red_level    (red_level),
    .green_level  (green_level),
    .blue_level   (blue_level)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("Timeout: results still outstanding at %0t", $realtime);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [LEVEL_W-1:0] colour_of(input int mean);
    int c;
    c = (mean / 256) * 255 / 10;
    if (c < 0) begin
      return '0;
    end else if (c > 255) begin
      return 8'd255;
    end else begin
      return LEVEL_W'(c);
    end
  endfunction

  function automatic reading_t predict_classification(input logic signed [SAMPLE_W-1:0] sx,
                                                      input logic signed [SAMPLE_W-1:0] sy,
                                                      input logic signed [SAMPLE_W-1:0] sz);
    logic signed [SAMPLE_W-1:0] smp [3];
    int       mean [3];
    int       t;
    int       l;
    int       mx;
    int       my;
    logic     updown;
    reading_t r;
    smp[0] = sx;
    smp[1] = sy;
    smp[2] = sz;
    for (int a = 0; a < 3; a++) begin
      axis_sum[a] = axis_sum[a] + smp[a] - sample_window[a][slot_ptr];
      sample_window[a][slot_ptr] = smp[a];
      mean[a] = int'(axis_sum[a] >>> WINDOW_LOG2_DEF);
    end
    slot_ptr = (slot_ptr + 1) % WIN_LEN;

    t = int'(tilt_thr);
    l = int'(lean_thr);
    mx = (mean[0] < 0) ? -mean[0] : mean[0];
    my = (mean[1] < 0) ? -mean[1] : mean[1];
    r.direction = DIR_TILTED;
    r.lean_right = 1'b0;
    r.lean_left = 1'b0;
    updown = 1'b0;
    if (mx > t || my > t) begin
      if (mean[0] < 0 && my < t) begin
        r.direction = DIR_DOWN;
        held_lit = 1'b1;
        held_pix = PIX_DOWN;
        updown = 1'b1;
      end
      if (mean[1] < 0 && mx < t) begin
        r.direction = DIR_RIGHT;
        held_lit = 1'b1;
        held_pix = PIX_RIGHT;
      end
      if (mean[0] > 0 && my < t) begin
        r.direction = DIR_UP;
        held_lit = 1'b1;
        held_pix = PIX_UP;
        updown = 1'b1;
      end
      if (mean[1] > 0 && mx < t) begin
        r.direction = DIR_LEFT;
        held_lit = 1'b1;
        held_pix = PIX_LEFT;
      end
      if (updown) begin
        r.lean_right = (mean[1] < -l);
        r.lean_left = (mean[1] > l);
      end
    end else if (mean[2] > 0) begin
      r.direction = DIR_FLAT;
      held_lit = 1'b0;
      held_pix = PIX_NONE;
    end else begin
      r.direction = DIR_FLIPPED;
    end

    r.mean_x = SAMPLE_W'(mean[0]);
    r.mean_y = SAMPLE_W'(mean[1]);
    r.mean_z = SAMPLE_W'(mean[2]);
    r.pixel_on = held_lit;
    r.pixel_number = held_lit ? held_pix : PIX_NONE;
    r.red = colour_of(mean[0]);
    r.green = colour_of(mean[1]);
    r.blue = colour_of(mean[2]);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want_v);
    error_count++;
    if (error_count <= 30) begin
      $display("MISMATCH %s at %0t: got %0d, expected %0d", what, $realtime, got, want_v);
    end
  endtask

  // check the result transaction first, then record the sample transaction
  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected result", int'(direction), -1);
      end else begin
        want = expected_readings.pop_front();
        readings_checked++;
        dir_seen[want.direction]++;
        if (avg_x !== want.mean_x) report_mismatch("avg_x", avg_x, want.mean_x);
        if (avg_y !== want.mean_y) report_mismatch("avg_y", avg_y, want.mean_y);
        if (avg_z !== want.mean_z) report_mismatch("avg_z", avg_z, want.mean_z);
        if (direction !== want.direction)
          report_mismatch("direction", direction, int'(want.direction));
        if (pixel_on !== want.pixel_on) report_mismatch("pixel_on", pixel_on, want.pixel_on);
        if (pixel_number !== want.pixel_number)
          report_mismatch("pixel_number", pixel_number, want.pixel_number);
        if (lean_right !== want.lean_right)
          report_mismatch("lean_right", lean_right, want.lean_right);
        if (lean_left !== want.lean_left)
          report_mismatch("lean_left", lean_left, want.lean_left);
        if (red_level !== want.red) report_mismatch("red_level", red_level, want.red);
        if (green_level !== want.green)
          report_mismatch("green_level", green_level, want.green);
        if (blue_level !== want.blue) report_mismatch("blue_level", blue_level, want.blue);
      end
    end
    if (!rst && in_valid && in_ready) begin
      expected_readings.push_back(predict_classification(accel_x, accel_y, accel_z));
      samples_sent++;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] sx,
                             input logic signed [SAMPLE_W-1:0] sy,
                             input logic signed [SAMPLE_W-1:0] sz);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    accel_x <= sx;
    accel_y <= sy;
    accel_z <= sz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [THR_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_TILT) begin
      tilt_thr = val;
    end else begin
      lean_thr = val;
    end
    @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] extreme_value();
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  // walk the window through flat, flipped, each direction, leans and boundaries
  task automatic test_directed_cases();
    send_idle_pct = 37;
    recv_idle_pct = 67;
    send_sample(16'sd0, 16'sd0, 16'sd4096);
    send_sample(16'sd12288, 16'sd0, -16'sd32768);
    send_sample(-16'sd32768, 16'sd0, 16'sd0);
    send_sample(16'sd0, -16'sd32768, 16'sd0);
    send_sample(16'sd32767, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd32767, 16'sd0);
    send_sample(16'sd32767, 16'sd0, 16'sd32767);
    send_sample(16'sd0, -16'sd6400, 16'sd0);
    send_sample(16'sd0, 16'sd12800, 16'sd0);
    send_sample(-16'sd32768, 16'sd16384, 16'sd0);
    send_sample(16'sd32767, 16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
    wait_drain();
  endtask

  task automatic test_threshold_extremes();
    write_reg(CFG_TILT, '0);
    write_reg(CFG_LEAN, '0);
    send_sample(16'sd20000, 16'sd0, 16'sd0);
    send_sample(16'sd0, -16'sd20000, 16'sd5000);
    send_sample(-16'sd1, 16'sd0, 16'sd32767);
    wait_drain();
    write_reg(CFG_TILT, '1);
    write_reg(CFG_LEAN, '1);
    send_sample(16'sd32767, 16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
    send_sample(16'sd0, 16'sd0, 16'sd0);
    wait_drain();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
    int phase_sent;
    int run_len;
    int kind;
    int base [3];
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int p = 0; p < 4; p++) begin
      wait_drain();
      case (p)
        0: begin
          write_reg(CFG_TILT, TILT_RESET);
          write_reg(CFG_LEAN, LEAN_RESET);
        end
        1: begin
          write_reg(CFG_TILT, THR_W'($urandom_range(64, 2600)));
          write_reg(CFG_LEAN, THR_W'($urandom_range(0, 1200)));
        end
        2: begin
          write_reg(CFG_TILT, THR_W'($urandom()));
          write_reg(CFG_LEAN, THR_W'($urandom()));
        end
        default: begin
          write_reg(CFG_TILT, THR_W'($urandom_range(0, 400)));
          write_reg(CFG_LEAN, THR_W'($urandom_range(0, 400)));
        end
      endcase
      phase_sent = 0;
      while (phase_sent < n_items / 4) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          // hold one orientation long enough for the mean to settle
          run_len = $urandom_range(8, 40);
          for (int a = 0; a < 3; a++) base[a] = int'($urandom_range(0, 8000)) - 4000;
          base[$urandom_range(0, 2)] = ($urandom_range(0, 1) ? 1 : -1) *
                                       int'($urandom_range(1500, 3200));
          repeat (run_len) begin
            send_sample(SAMPLE_W'(base[0] + int'($urandom_range(0, 400)) - 200),
                        SAMPLE_W'(base[1] + int'($urandom_range(0, 400)) - 200),
                        SAMPLE_W'(base[2] + int'($urandom_range(0, 400)) - 200));
          end
        end else if (kind < 9) begin
          run_len = $urandom_range(1, 5);
          repeat (run_len) begin
            send_sample(SAMPLE_W'($urandom()), SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
          end
        end else begin
          run_len = $urandom_range(1, 4);
          repeat (run_len) send_sample(extreme_value(), extreme_value(), extreme_value());
        end
        phase_sent += run_len;
      end
    end
    wait_drain();
  endtask

  // stall the output long enough to back up the input, then drain fully
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 400;
    repeat (60) begin
      send_sample(SAMPLE_W'(int'($urandom_range(0, 6000)) - 3000),
                  SAMPLE_W'(int'($urandom_range(0, 6000)) - 3000),
                  SAMPLE_W'(int'($urandom_range(0, 6000)) - 3000));
    end
    wait_drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_cases();
    test_threshold_extremes();
    test_random_traffic(37, 67, 580);
    test_random_traffic(67, 37, 580);
    test_backpressure();
    test_random_traffic(0, 0, 580);

    wait_drain();
    repeat (10) @(negedge clk);
    $display("Checked %0d results from %0d samples across swept tilt and lean thresholds",
             readings_checked, samples_sent);
    $display("Directions: flat %0d flipped %0d tilted %0d down %0d right %0d up %0d left %0d",
             dir_seen[0], dir_seen[1], dir_seen[2], dir_seen[3], dir_seen[4], dir_seen[5],
             dir_seen[6]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
